// File: sv/compass_heading_from_xy_core_assert.svh
// Assertion macros shared by the compass heading RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef COMPASS_HEADING_FROM_XY_CORE_ASSERT_SVH
`define COMPASS_HEADING_FROM_XY_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define CFH_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define CFH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cfh_pkg.sv
// Package for the compass heading block: widths, angle constants, arctangent table
// and the record that travels down the CORDIC chain. No dependencies.
`default_nettype none

package cfh_pkg;

    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned XY_W           = 27;
    localparam int unsigned Z_W            = 26;
    localparam int unsigned SUM_W          = 28;
    localparam int unsigned HEADING_W      = 9;
    localparam int unsigned STEPS_DEFAULT  = 16;
    localparam int unsigned STEPS_MAX      = 24;

    localparam logic [HEADING_W-1:0] OFFSET_RESET = 9'd70;
    localparam logic [HEADING_W-1:0] HEADING_FULL = 9'd360;

    localparam logic signed [Z_W-1:0] DEG_90_Q16  = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] DEG_180_Q16 = Z_W'(180 * 65536);
    localparam logic signed [SUM_W-1:0] DEG_360_Q16 = SUM_W'(360 * 65536);

    // atan(2^-i) in degrees, 16 fractional bits, rounded.
    localparam logic [21:0] ATAN_Q16 [0:STEPS_MAX-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef struct packed {
        logic                   valid;
        logic                   bypass;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cfh_vec_t;

endpackage

`default_nettype wire

// File: sv/cfh_cell.sv
// One CORDIC vectoring cell of the heading chain, with its own output register.
// Depends on cfh_pkg for the vector record and the arctangent table.
`default_nettype none

module cfh_cell
    import cfh_pkg::*;
#(
    parameter int unsigned STAGE = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  cfh_vec_t d,
    output cfh_vec_t q
);

    logic signed [XY_W-1:0] x_shift;
    logic signed [XY_W-1:0] y_shift;
    logic signed [Z_W-1:0]  atan_step;
    logic                   rot_pos;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;

    logic                   valid_reg;
    logic                   bypass_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    assign x_shift   = d.x >>> STAGE;
    assign y_shift   = d.y >>> STAGE;
    assign atan_step = Z_W'(ATAN_Q16[STAGE]);
    assign rot_pos   = (d.y > 0);

    always_comb
    begin
        if (rot_pos)
        begin
            x_next = d.x + y_shift;
            y_next = d.y - x_shift;
            z_next = d.z + atan_step;
        end
        else
        begin
            x_next = d.x - y_shift;
            y_next = d.y + x_shift;
            z_next = d.z - atan_step;
        end
        // Axis-aligned vectors already carry their exact angle.
        if (d.bypass)
        begin
            z_next = d.z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bypass_reg <= d.bypass;
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
        end
    end

    assign q.valid  = valid_reg;
    assign q.bypass = bypass_reg;
    assign q.x      = x_reg;
    assign q.y      = y_reg;
    assign q.z      = z_reg;

endmodule

`default_nettype wire

// File: sv/cfh_wrap.sv
// Final stage: adds the declination, wraps into 0..360, truncates and mirrors
// the heading; holds the output register. Depends on cfh_pkg.
`default_nettype none

module cfh_wrap
    import cfh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cfh_vec_t             d,
    input  logic [HEADING_W-1:0] offset,
    output logic                 heading_valid,
    output logic [HEADING_W-1:0] heading_degrees
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrapped;
    logic [HEADING_W-1:0]    whole;
    logic [HEADING_W-1:0]    heading_next;

    logic                    valid_reg;
    logic [HEADING_W-1:0]    heading_reg;

    assign sum = SUM_W'(d.z) + $signed({3'b000, offset, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        wrapped = sum;
        if (sum > DEG_360_Q16)
        begin
            wrapped = sum - DEG_360_Q16;
        end
        else if (sum < 0)
        begin
            wrapped = sum + DEG_360_Q16;
        end
    end

    // The wrapped angle is never negative, so its integer part is a plain slice.
    assign whole        = wrapped[FRAC_BITS +: HEADING_W];
    assign heading_next = HEADING_FULL - whole;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            heading_reg <= heading_next;
        end
    end

    assign heading_valid   = valid_reg;
    assign heading_degrees = heading_reg;

endmodule

`default_nettype wire

// File: sv/compass_heading_from_xy_core.sv
// Compass heading core: quadrant pre-rotation, a chain of CORDIC cells, and the
// declination/wrap stage. Depends on cfh_pkg, cfh_cell, cfh_wrap and the assert header.
//
// Usage:
//   Sample channel: sample_valid/sample_stall carry one reading per beat, the
//   X and Y axes as big-endian byte pairs (x_high, x_low, y_high, y_low).
//   Heading channel: heading_valid/heading_stall carry heading_degrees, which is
//   360 minus the truncated heading after the declination offset and wrap.
//   Config channel: cfg_valid/cfg_ready write cfg_data into the declination
//   offset; cfg_ready is always high. Write it only while the core is empty.
// A beat passes one pre-rotation register, one register per CORDIC cell and
// one output register. Throughput is one beat per cycle while heading_stall
// does not hold the chain; each CORDIC iteration is its own cell.
// When the output register is full and heading_stall is high, the whole chain
// holds and sample_stall goes high in the same cycle; nothing is dropped.
// Reset empties the chain (all valid flags clear) and sets the offset to 70.
`default_nettype none

`include "compass_heading_from_xy_core_assert.svh"

module compass_heading_from_xy_core
    import cfh_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = STEPS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic [7:0]           x_high,
    input  logic [7:0]           x_low,
    input  logic [7:0]           y_high,
    input  logic [7:0]           y_low,
    output logic                 heading_valid,
    input  logic                 heading_stall,
    output logic [HEADING_W-1:0] heading_degrees,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [HEADING_W-1:0] cfg_data
);

    logic                   en;
    logic [HEADING_W-1:0]   offset_reg;

    logic signed [15:0]     x_raw;
    logic signed [15:0]     y_raw;
    logic signed [XY_W-1:0] x_scaled;
    logic signed [XY_W-1:0] y_scaled;

    logic                   pre_valid_reg;
    logic                   pre_bypass_next;
    logic                   pre_bypass_reg;
    logic signed [XY_W-1:0] pre_x_next;
    logic signed [XY_W-1:0] pre_x_reg;
    logic signed [XY_W-1:0] pre_y_next;
    logic signed [XY_W-1:0] pre_y_reg;
    logic signed [Z_W-1:0]  pre_z_next;
    logic signed [Z_W-1:0]  pre_z_reg;

    cfh_vec_t               stage_vec [0:CORDIC_STEPS];

    // The chain moves unless a finished heading is held by the receiver.
    assign en           = !(heading_valid && heading_stall);
    assign sample_stall = !en;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_data;
        end
    end

    assign x_raw    = $signed({x_high, x_low});
    assign y_raw    = $signed({y_high, y_low});
    assign x_scaled = {{(XY_W-24){x_raw[15]}}, x_raw, 8'b0};
    assign y_scaled = {{(XY_W-24){y_raw[15]}}, y_raw, 8'b0};

    always_comb
    begin
        pre_bypass_next = (y_raw == 16'sd0) || (x_raw == 16'sd0);
        pre_x_next      = x_scaled;
        pre_y_next      = y_scaled;
        pre_z_next      = '0;
        if (y_raw == 16'sd0)
        begin
            pre_z_next = (x_raw < 0) ? DEG_180_Q16 : '0;
        end
        else if (x_raw == 16'sd0)
        begin
            pre_z_next = (y_raw > 0) ? DEG_90_Q16 : -DEG_90_Q16;
        end
        else if (x_raw < 0)
        begin
            // Rotate into the right half plane before the CORDIC iterations.
            if (y_raw >= 0)
            begin
                pre_x_next = y_scaled;
                pre_y_next = -x_scaled;
                pre_z_next = DEG_90_Q16;
            end
            else
            begin
                pre_x_next = -y_scaled;
                pre_y_next = x_scaled;
                pre_z_next = -DEG_90_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_bypass_reg <= pre_bypass_next;
            pre_x_reg      <= pre_x_next;
            pre_y_reg      <= pre_y_next;
            pre_z_reg      <= pre_z_next;
        end
    end

    assign stage_vec[0].valid  = pre_valid_reg;
    assign stage_vec[0].bypass = pre_bypass_reg;
    assign stage_vec[0].x      = pre_x_reg;
    assign stage_vec[0].y      = pre_y_reg;
    assign stage_vec[0].z      = pre_z_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        cfh_cell #(
            .STAGE (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (stage_vec[i]),
            .q     (stage_vec[i+1])
        );
    end

    cfh_wrap u_wrap (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .d               (stage_vec[CORDIC_STEPS]),
        .offset          (offset_reg),
        .heading_valid   (heading_valid),
        .heading_degrees (heading_degrees)
    );

    `CFH_ASSERT_HOLDS(a_heading_range, heading_valid, heading_degrees <= HEADING_FULL,
        "heading above 360")
    `CFH_ASSERT_NEXT(a_last_cell_drains, en && stage_vec[CORDIC_STEPS].valid, heading_valid,
        "finished vector did not reach the output register")
    `CFH_ASSERT_NEXT(a_bubble_drains, en && !stage_vec[CORDIC_STEPS].valid, !heading_valid,
        "output register shows a beat that was never computed")
    `CFH_ASSERT_HOLDS(a_prerot_half_plane, stage_vec[0].valid && !stage_vec[0].bypass,
        stage_vec[0].x > 0, "pre-rotation left the vector outside the right half plane")

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for compass_heading_from_xy_core: a queue-fed driver and a
// checking monitor, with an in-line CORDIC heading predictor. Depends on cfh_pkg.

module testbench
    import cfh_pkg::*;
();

    localparam int STEPS          = 16;
    localparam int LATENCY        = STEPS + 2;
    localparam int IDLE_PCT       = 33;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 148;
    localparam longint ONE_DEG    = 65536;
    localparam longint ARCTAN_Q16 [STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [7:0] x_high;
        logic [7:0] x_low;
        logic [7:0] y_high;
        logic [7:0] y_low;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic [7:0]           x_high = '0;
    logic [7:0]           x_low = '0;
    logic [7:0]           y_high = '0;
    logic [7:0]           y_low = '0;
    logic                 heading_valid;
    logic                 heading_stall = 1'b0;
    logic [HEADING_W-1:0] heading_degrees;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [HEADING_W-1:0] cfg_data = '0;

    reading_t             pending_readings [$];
    logic [HEADING_W-1:0] expected_headings [$];
    logic [HEADING_W-1:0] offset_now = OFFSET_RESET;
    reading_t             next_reading;
    logic [HEADING_W-1:0] oldest_heading;
    logic                 steady = 1'b0;
    logic [7:0]           hold_request = '0;
    logic [7:0]           hold_seen = '0;
    int                   hold_left = 0;
    int                   quiet_cycles = 0;
    int                   error_count = 0;

    compass_heading_from_xy_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .x_high          (x_high),
        .x_low           (x_low),
        .y_high          (y_high),
        .y_low           (y_low),
        .heading_valid   (heading_valid),
        .heading_stall   (heading_stall),
        .heading_degrees (heading_degrees),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Heading in whole degrees, clockwise, for one reading and offset.
    function automatic logic [HEADING_W-1:0] heading_for(reading_t r,
                                                         logic [HEADING_W-1:0] offset);
        longint xv, yv, x, y, z, nx, ny, off, sum, whole;
        xv = $signed({r.x_high, r.x_low});
        yv = $signed({r.y_high, r.y_low});
        z = 0;
        if (yv == 0)
        begin
            z = (xv < 0) ? 180 * ONE_DEG : 0;
        end
        else if (xv == 0)
        begin
            z = (yv > 0) ? 90 * ONE_DEG : -90 * ONE_DEG;
        end
        else
        begin
            x = xv * 256;
            y = yv * 256;
            // Fold the left half plane onto the right one before iterating.
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    nx = y;
                    ny = -x;
                    z = 90 * ONE_DEG;
                end
                else
                begin
                    nx = -y;
                    ny = x;
                    z = -90 * ONE_DEG;
                end
                x = nx;
                y = ny;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                if (y > 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += ARCTAN_Q16[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= ARCTAN_Q16[i];
                end
                x = nx;
                y = ny;
            end
        end
        off = offset;
        sum = z + off * ONE_DEG;
        // A sum of exactly 360 degrees is kept and maps to a heading of 0.
        if (sum > 360 * ONE_DEG)
            sum -= 360 * ONE_DEG;
        if (sum < 0)
            sum += 360 * ONE_DEG;
        whole = sum >>> 16;
        return HEADING_W'(360 - whole);
    endfunction

    function automatic void add_reading(logic [15:0] x, logic [15:0] y);
        pending_readings.push_back({x[15:8], x[7:0], y[15:8], y[7:0]});
    endfunction

    function automatic logic [15:0] extreme_axis();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_readings.size() != 0 || sample_valid || expected_headings.size() != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Sample driver: a stalled beat stays on the bus; otherwise offer the next reading or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (sample_valid)
                expected_headings.push_back(heading_for({x_high, x_low, y_high, y_low},
                                                        offset_now));
            if (pending_readings.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                next_reading = pending_readings.pop_front();
                sample_valid <= 1'b1;
                x_high <= next_reading.x_high;
                x_low <= next_reading.x_low;
                y_high <= next_reading.y_high;
                y_low <= next_reading.y_low;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Heading monitor: check each beat, then choose the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_stall <= 1'b0;
        end
        else
        begin
            if (heading_valid && !heading_stall)
            begin
                if (expected_headings.size() == 0)
                begin
                    $error("heading_degrees: no beat expected, actual %0d", heading_degrees);
                    error_count++;
                end
                else
                begin
                    oldest_heading = expected_headings.pop_front();
                    if (heading_degrees !== oldest_heading)
                    begin
                        $error("heading_degrees: expected %0d, actual %0d",
                               oldest_heading, heading_degrees);
                        error_count++;
                    end
                end
            end
            if (hold_seen != hold_request)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                heading_stall <= 1'b1;
            end
            else
            begin
                heading_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (heading_valid && !heading_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("compass_heading_from_xy_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [HEADING_W-1:0] offset_value;
        logic [15:0]          xv;
        logic [15:0]          yv;
        int                   pick;

        // Directed readings at the reset offset: zero vector, axes and corners.
        add_reading(16'h0000, 16'h0000);
        add_reading(16'h0001, 16'h0000);
        add_reading(16'hFFFF, 16'h0000);
        add_reading(16'h0000, 16'h0001);
        add_reading(16'h0000, 16'hFFFF);
        add_reading(16'h8000, 16'h0000);
        add_reading(16'h0000, 16'h8000);
        add_reading(16'h0000, 16'h7FFF);
        add_reading(16'h7FFF, 16'h0000);
        add_reading(16'h7FFF, 16'h7FFF);
        add_reading(16'h8000, 16'h8000);
        add_reading(16'h8000, 16'h7FFF);
        add_reading(16'h7FFF, 16'h8000);
        add_reading(16'hFFFF, 16'h0001);
        add_reading(16'h0001, 16'hFFFF);
        add_reading(16'hFFFF, 16'hFFFF);
        add_reading(16'h0100, 16'hFF01);
        add_reading(16'hFED4, 16'h0001);
        add_reading(16'd1000, 16'd3);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: offset_value = 9'd0;
                1: offset_value = 9'd359;
                2: offset_value = 9'd511;
                3: offset_value = 9'd360;
                4: offset_value = 9'd180;
                5: offset_value = 9'd1;
                default: offset_value = HEADING_W'($urandom_range(359));
            endcase

            // The core is empty here, so the offset can change.
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= offset_value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            offset_now = offset_value;

            @(negedge clk);
            steady = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                xv = 16'($urandom);
                yv = 16'($urandom);
                if (pick < 10)
                begin
                    if ($urandom_range(1))
                        xv = '0;
                    else
                        yv = '0;
                end
                else if (pick < 20)
                begin
                    xv = extreme_axis();
                    yv = extreme_axis();
                end
                add_reading(xv, yv);
            end

            // Hold the heading side long enough for the core to back up into the sample side.
            if (phase == 1)
            begin
                @(posedge clk);
                hold_request <= hold_request + 8'd1;
            end

            // The sender pauses here until every heading of the phase has come back.
            wait_drained();
            steady = 1'b0;
        end

        if (error_count == 0)
            $display("compass_heading_from_xy_core: match");
        else
            $display("compass_heading_from_xy_core: mismatch");
        $finish;
    end

endmodule
